// ===== rtl/stuffed_frame_encoder_crc8_unit_macros.svh =====
// assertion macros for the stuffed frame encoder
// no dependencies; included by modules that check their own logic
`ifndef STUFFED_FRAME_ENCODER_CRC8_UNIT_MACROS_SVH
`define STUFFED_FRAME_ENCODER_CRC8_UNIT_MACROS_SVH

// same-cycle implication, checked on clock, off during reset
`define SFE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on clock, off during reset
`define SFE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sfe_pkg.sv =====
// shared types, constants and crc helper for the stuffed frame encoder
// no dependencies
package sfe_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] BYTE_PREAMBLE = 8'hAA;
   localparam logic [7:0] BYTE_START    = 8'hAC;
   localparam logic [7:0] BYTE_END      = 8'hAD;
   localparam logic [7:0] BYTE_ESC      = 8'hAE;
   localparam logic [7:0] BYTE_ESC_BASE = 8'h20;
   localparam logic [7:0] BYTE_NIB_MASK = 8'h0F;
   localparam logic [7:0] BYTE_CMD0     = 8'h30;
   localparam logic [7:0] BYTE_CMD1     = 8'h82;
   localparam logic [7:0] BYTE_MODE_NZ  = 8'h09;
   localparam logic [7:0] BYTE_MODE_Z   = 8'h08;
   localparam logic [7:0] BYTE_ARG_NZ   = 8'h64;
   localparam logic [7:0] BYTE_ARG_Z    = 8'h00;
   localparam logic [7:0] CRC_POLY      = 8'h8C;

   // one byte of reflected crc-8, poly 0x8c
   function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] data);
      logic [7:0] c;
      c = acc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // crc state after the four fixed header bytes
   localparam logic [7:0] CRC_HDR_NZ =
      crc8_byte(crc8_byte(crc8_byte(crc8_byte(8'h00, BYTE_CMD0), BYTE_CMD1),
                          BYTE_MODE_NZ), BYTE_ARG_NZ);
   localparam logic [7:0] CRC_HDR_Z =
      crc8_byte(crc8_byte(crc8_byte(crc8_byte(8'h00, BYTE_CMD0), BYTE_CMD1),
                          BYTE_MODE_Z), BYTE_ARG_Z);

   typedef struct packed {
      logic [15:0] value;
      logic [7:0]  crc;
   } sfe_entry_type;

   typedef struct packed {
      logic             empty;
      logic [CNT_W-1:0] count;
   } sfe_qstat_type;

endpackage

// ===== rtl/sfe_queue.sv =====
// four-entry queue of classified frames between front and back
// depends on sfe_pkg
module sfe_queue import sfe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  sfe_entry_type push_data,
   input  logic          pop,
   output sfe_entry_type head,
   output sfe_qstat_type status
);

   sfe_entry_type    entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

endmodule

// ===== rtl/sfe_front.sv =====
// front end: takes drive values and computes the frame crc over two stages
// depends on sfe_pkg
module sfe_front import sfe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  logic [15:0]   req_drive_value,
   input  sfe_qstat_type q_status,
   output logic          q_push,
   output sfe_entry_type q_data
);

   logic          s1_valid_ff, s1_valid_in;
   logic [15:0]   s1_value_ff;
   logic [7:0]    s1_crc_ff, s1_crc_in;
   logic          accept;
   logic [CNT_W:0] used;

   // slots taken or promised: queued entries plus the one in flight
   assign used     = {1'b0, q_status.count} + (CNT_W+1)'(s1_valid_ff);
   assign req_full = (used >= (CNT_W+1)'(QUEUE_DEPTH));
   assign accept   = req_push && !req_full;

   always_comb begin
      s1_valid_in = accept;
      s1_crc_in   = crc8_byte((req_drive_value != 16'h0000) ? CRC_HDR_NZ : CRC_HDR_Z,
                              req_drive_value[15:8]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_value_ff <= req_drive_value;
         s1_crc_ff   <= s1_crc_in;
      end
   end

   // low byte finishes the crc on the way into the queue
   assign q_push       = s1_valid_ff;
   assign q_data.value = s1_value_ff;
   assign q_data.crc   = crc8_byte(s1_crc_ff, s1_value_ff[7:0]);

endmodule

// ===== rtl/sfe_back.sv =====
// back end: walks the head frame byte by byte with escaping into the output register
// depends on sfe_pkg and the assertion macro header
`include "stuffed_frame_encoder_crc8_unit_macros.svh"
module sfe_back import sfe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  sfe_entry_type head,
   input  sfe_qstat_type q_status,
   output logic          q_pop,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output logic [7:0]    rsp_out_byte,
   output logic          rsp_frame_last
);

   typedef enum logic [3:0] {
      POS_PRE0, POS_PRE1, POS_START, POS_CMD0, POS_CMD1, POS_MODE, POS_ARG,
      POS_HI, POS_LO, POS_CRC, POS_CLOSE
   } pos_type;

   pos_type    pos_ff, pos_step;
   logic       esc_ff;
   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;

   logic       nonzero;
   logic [7:0] raw;
   logic       is_code;
   logic       advance;

   assign nonzero = (head.value != 16'h0000);
   assign advance = !q_status.empty && (!out_valid_ff || rsp_pop);

   always_comb begin
      raw      = BYTE_PREAMBLE;
      pos_step = POS_PRE0;
      case (pos_ff)
         POS_PRE0:  begin raw = BYTE_PREAMBLE;  pos_step = POS_PRE1;  end
         POS_PRE1:  begin raw = BYTE_PREAMBLE;  pos_step = POS_START; end
         POS_START: begin raw = BYTE_START;     pos_step = POS_CMD0;  end
         POS_CMD0:  begin raw = BYTE_CMD0;      pos_step = POS_CMD1;  end
         POS_CMD1:  begin raw = BYTE_CMD1;      pos_step = POS_MODE;  end
         POS_MODE:  begin
            raw      = nonzero ? BYTE_MODE_NZ : BYTE_MODE_Z;
            pos_step = POS_ARG;
         end
         POS_ARG:   begin
            raw      = nonzero ? BYTE_ARG_NZ : BYTE_ARG_Z;
            pos_step = POS_HI;
         end
         POS_HI:    begin raw = head.value[15:8]; pos_step = POS_LO;   end
         POS_LO:    begin raw = head.value[7:0];  pos_step = POS_CRC;  end
         POS_CRC:   begin raw = head.crc;         pos_step = POS_CLOSE; end
         POS_CLOSE: begin raw = BYTE_END;         pos_step = POS_PRE0; end
         default:   begin raw = BYTE_PREAMBLE;    pos_step = POS_PRE0; end
      endcase
   end

   // only value and crc bytes can collide with the framing codes
   always_comb begin
      is_code = (pos_ff inside {POS_HI, POS_LO, POS_CRC}) &&
                (raw inside {BYTE_START, BYTE_END, BYTE_ESC});
   end

   assign q_pop = advance && (pos_ff == POS_CLOSE);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_PRE0;
         esc_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         out_byte_ff  <= BYTE_PREAMBLE;
         out_last_ff  <= 1'b0;
      end else begin
         // a new byte is loaded, or the current one stays until popped
         out_valid_ff <= advance || (out_valid_ff && !rsp_pop);
         if (advance) begin
            out_last_ff  <= (pos_ff == POS_CLOSE);
            if (esc_ff) begin
               out_byte_ff <= BYTE_ESC_BASE + (raw & BYTE_NIB_MASK);
               esc_ff      <= 1'b0;
               pos_ff      <= pos_step;
            end else if (is_code) begin
               out_byte_ff <= BYTE_ESC;
               esc_ff      <= 1'b1;
            end else begin
               out_byte_ff <= raw;
               pos_ff      <= pos_step;
            end
         end
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_frame_last = out_last_ff;

   `SFE_ASSERT_NOW(a_esc_pos, esc_ff, (pos_ff == POS_HI || pos_ff == POS_LO || pos_ff == POS_CRC), "escape pending outside value or crc byte")
   `SFE_ASSERT_NOW(a_pop_close, q_pop, (pos_ff == POS_CLOSE && !esc_ff && !q_status.empty), "frame retired before its closing byte")
   `SFE_ASSERT_NOW(a_last_end, (out_valid_ff && out_last_ff), (out_byte_ff == BYTE_END), "last beat is not the closing byte")
   `SFE_ASSERT_NEXT(a_esc_follow, (advance && is_code && !esc_ff), esc_ff, "escape code not followed by its second byte")

endmodule

// ===== rtl/stuffed_frame_encoder_crc8_unit.sv =====
// top level of the byte-stuffed command frame encoder with crc-8
// depends on sfe_pkg, sfe_front, sfe_queue and sfe_back
//
// Takes one signed 16-bit drive value per input beat and produces one motor
// command frame as a stream of byte beats: 0xAA 0xAA 0xAC, the six payload
// bytes (0x30 0x82, mode and argument bytes, value high and low byte), the
// crc-8 (reflected, poly 0x8C, init 0) and the closing 0xAD flagged by
// rsp_frame_last. Value and crc bytes equal to 0xAC/0xAD/0xAE go out as 0xAE
// then 0x20 plus the low nibble. A frame is 11 to 14 output beats. With
// rsp_pop held high and the queue backed up the output register moves one
// byte per cycle; that byte-per-cycle output register sets the rate. The
// front computes the crc, high byte before its register and low byte after
// it, and feeds a four-frame queue, so values are taken back to back while
// earlier frames still stream out. When idle, a value passes the front
// register, the queue and the output register before its first byte shows.
module stuffed_frame_encoder_crc8_unit import sfe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // drive value beats
   input  logic        req_push,
   output logic        req_full,
   input  logic [15:0] req_drive_value,
   // frame byte beats
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_last
);

   // front to queue
   logic          q_push;
   sfe_entry_type q_data;
   // queue to back
   sfe_entry_type q_head;
   sfe_qstat_type q_status;
   logic          q_pop;

   // classification and crc
   sfe_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_drive_value (req_drive_value),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_data          (q_data)
   );

   // decouples crc front from the byte streamer
   sfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   // framing, escaping and output register
   sfe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .q_status       (q_status),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
